// ===== rtl/core/tccs_pkg.sv =====
// shared constants, codes and types of the text console
`default_nettype none
package tccs_pkg;

   localparam int COLUMNS  = 80;
   localparam int ROWS     = 25;
   localparam int TAB_STOP = 8;
   localparam int CELLS    = ROWS * COLUMNS;

   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int ATTR_W = 8;
   localparam int CHAR_W = 8;
   localparam int CELL_W = ATTR_W + CHAR_W;
   localparam int KIND_W = 2;
   localparam int REQ_W  = 24;
   localparam int RSP_W  = 32;

   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h17;
   localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
   localparam logic [CHAR_W-1:0] CH_LF      = 8'd10;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

   localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   typedef struct packed {
      logic              we;
      logic              re;
      logic              linear;
      logic [ADDR_W-1:0] index;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [CELL_W-1:0] wdata;
   } mem_req_type;

endpackage
`default_nettype wire

// ===== rtl/core/tccs_cell_store.sv =====
// cell store with circular row mapping and registered read port
`default_nettype none
module tccs_cell_store (
   input  wire logic                          clock,
   input  wire tccs_pkg::mem_req_type         mem_req,
   input  wire logic [tccs_pkg::ROW_W-1:0]    top_row,
   output logic      [tccs_pkg::CELL_W-1:0]   rdata
);

   localparam logic [tccs_pkg::ADDR_W-1:0] COLS_A = tccs_pkg::ADDR_W'(tccs_pkg::COLUMNS);
   localparam logic [tccs_pkg::ROW_W:0]    ROWS_S = (tccs_pkg::ROW_W + 1)'(tccs_pkg::ROWS);

   logic [tccs_pkg::CELL_W-1:0] cell_mem [0:tccs_pkg::CELLS-1];
   logic [tccs_pkg::CELL_W-1:0] rdata_ff;

   logic [tccs_pkg::ROW_W:0]    row_sum;
   logic [tccs_pkg::ROW_W-1:0]  phys_row;
   logic [tccs_pkg::ADDR_W-1:0] row_base;
   logic [tccs_pkg::ADDR_W-1:0] addr;

   // logical row to physical row, then row-major address, or the linear index as is
   always_comb begin
      row_sum = {1'b0, mem_req.row} + {1'b0, top_row};
      if (row_sum >= ROWS_S) begin
         phys_row = tccs_pkg::ROW_W'(row_sum - ROWS_S);
      end else begin
         phys_row = row_sum[tccs_pkg::ROW_W-1:0];
      end
      row_base = tccs_pkg::ADDR_W'(phys_row) * COLS_A;
      if (mem_req.linear) begin
         addr = mem_req.index;
      end else begin
         addr = row_base + tccs_pkg::ADDR_W'(mem_req.col);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         cell_mem[addr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rdata_ff <= cell_mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== rtl/core/text_console_cursor_scroll_top.sv =====
// text console top level: cursor sequencer, response register and cell store
//
// channel  direction  handshake             payload
// req      in         req_tvalid/tready     tuser kind, tdata char/read_row/read_col
// rsp      out        rsp_tvalid/tready     tdata cell/cursor_row/cursor_col/scrolled
// csr      in         csr_valid/csr_ready   csr_wdata attribute
//
// printable put passes exec, write and done; return, newline, tab, read and unused kind skip write
// a scroll blanks all 80 columns of the new bottom row through the write port
// clear sweeps every cell (2000) through the single write port
// after reset a clearing pass over all 2000 cells runs with req_tready low; csr is always ready
// a held response stalls the next item only at its final step, not at acceptance
`default_nettype none
module text_console_cursor_scroll_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [tccs_pkg::KIND_W-1:0]   req_tuser,  // kind
   input  wire logic [tccs_pkg::REQ_W-1:0]    req_tdata,  // char_code, read_row, read_col
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic      [tccs_pkg::RSP_W-1:0]    rsp_tdata,  // cell_value, cursor_row,
                                                          // cursor_col, scrolled
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [tccs_pkg::ATTR_W-1:0]   csr_wdata
);

   typedef enum logic [6:0] {
      ST_INIT   = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_EXEC   = 7'b0000100,
      ST_SCROLL = 7'b0001000,
      ST_WRITE  = 7'b0010000,
      ST_FILL   = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   localparam logic [tccs_pkg::ROW_W-1:0]  LAST_ROW  = tccs_pkg::ROW_W'(tccs_pkg::ROWS - 1);
   localparam logic [tccs_pkg::COL_W-1:0]  COLS_C    = tccs_pkg::COL_W'(tccs_pkg::COLUMNS);
   localparam logic [tccs_pkg::COL_W-1:0]  TAB_MASK  = ~tccs_pkg::COL_W'(tccs_pkg::TAB_STOP - 1);
   localparam logic [tccs_pkg::COL_W-1:0]  TAB_C     = tccs_pkg::COL_W'(tccs_pkg::TAB_STOP);
   localparam logic [tccs_pkg::ADDR_W-1:0] LAST_CELL = tccs_pkg::ADDR_W'(tccs_pkg::CELLS - 1);
   localparam logic [tccs_pkg::ADDR_W-1:0] LAST_COL  = tccs_pkg::ADDR_W'(tccs_pkg::COLUMNS - 1);

   state_type                   state_ff, state_in;
   logic [tccs_pkg::ADDR_W-1:0] sweep_ff, sweep_in;
   logic [tccs_pkg::ROW_W-1:0]  top_ff, top_in;
   logic [tccs_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [tccs_pkg::COL_W-1:0]  col_ff, col_in;
   logic [tccs_pkg::ATTR_W-1:0] attr_ff, attr_in;
   logic                        scrolled_ff, scrolled_in;
   logic                        hit_ff, hit_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tccs_pkg::RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [tccs_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [tccs_pkg::CHAR_W-1:0] char_ff, char_in;
   logic [tccs_pkg::ROW_W-1:0]  rrow_ff, rrow_in;
   logic [tccs_pkg::COL_W-1:0]  rcol_ff, rcol_in;

   tccs_pkg::mem_req_type       mem_req;
   logic [tccs_pkg::CELL_W-1:0] mem_rdata;

   logic                        printable;
   logic [tccs_pkg::COL_W-1:0]  tab_col;
   logic                        need_nl;
   logic                        rsp_load;
   logic [tccs_pkg::CELL_W-1:0] cell_out;
   logic [tccs_pkg::CELL_W-1:0] blank;

   assign printable  = (char_ff != tccs_pkg::CH_CR) && (char_ff != tccs_pkg::CH_LF) &&
                       (char_ff != tccs_pkg::CH_TAB);
   assign tab_col    = (col_ff & TAB_MASK) + TAB_C;
   assign blank      = {attr_ff, tccs_pkg::CH_SPACE};
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign cell_out   = hit_ff ? mem_rdata : '0;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      if (char_ff == tccs_pkg::CH_CR) begin
         need_nl = 1'b0;
      end else if (char_ff == tccs_pkg::CH_LF) begin
         need_nl = 1'b1;
      end else if (char_ff == tccs_pkg::CH_TAB) begin
         need_nl = (tab_col >= COLS_C);
      end else begin
         need_nl = (col_ff >= COLS_C);
      end
   end

   always_comb begin
      state_in    = state_ff;
      sweep_in    = sweep_ff;
      top_in      = top_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      scrolled_in = scrolled_ff;
      hit_in      = hit_ff;
      kind_in     = kind_ff;
      char_in     = char_ff;
      rrow_in     = rrow_ff;
      rcol_in     = rcol_ff;
      attr_in     = (csr_valid && csr_ready) ? csr_wdata : attr_ff;
      mem_req     = '0;

      case (state_ff)
         ST_INIT, ST_FILL: begin
            mem_req.we     = 1'b1;
            mem_req.linear = 1'b1;
            mem_req.index  = sweep_ff;
            mem_req.wdata  = (state_ff == ST_INIT) ? {tccs_pkg::RESET_ATTR, tccs_pkg::CH_SPACE}
                                                   : blank;
            sweep_in       = sweep_ff + tccs_pkg::ADDR_W'(1);
            if (sweep_ff == LAST_CELL) begin
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_DONE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in     = req_tuser;
               char_in     = req_tdata[7:0];
               rrow_in     = req_tdata[12:8];
               rcol_in     = req_tdata[19:13];
               scrolled_in = 1'b0;
               hit_in      = 1'b0;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            case (kind_ff)
               tccs_pkg::KIND_PUT: begin
                  if (need_nl) begin
                     col_in = '0;
                     if (row_ff == LAST_ROW) begin
                        top_in      = (top_ff == LAST_ROW) ? '0
                                                           : top_ff + tccs_pkg::ROW_W'(1);
                        scrolled_in = 1'b1;
                        sweep_in    = '0;
                        state_in    = ST_SCROLL;
                     end else begin
                        row_in = row_ff + tccs_pkg::ROW_W'(1);
                     end
                  end else if (char_ff == tccs_pkg::CH_CR) begin
                     col_in = '0;
                  end else if (char_ff == tccs_pkg::CH_TAB) begin
                     col_in = tab_col;
                  end
                  if (printable && !(need_nl && row_ff == LAST_ROW)) begin
                     state_in = ST_WRITE;
                  end
               end
               tccs_pkg::KIND_CLEAR: begin
                  row_in   = '0;
                  col_in   = '0;
                  top_in   = '0;
                  sweep_in = '0;
                  state_in = ST_FILL;
               end
               tccs_pkg::KIND_READ: begin
                  hit_in      = (rrow_ff < tccs_pkg::ROW_W'(tccs_pkg::ROWS)) && (rcol_ff < COLS_C);
                  mem_req.re  = 1'b1;
                  mem_req.row = rrow_ff;
                  mem_req.col = rcol_ff;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_SCROLL: begin
            mem_req.we    = 1'b1;
            mem_req.row   = LAST_ROW;
            mem_req.col   = sweep_ff[tccs_pkg::COL_W-1:0];
            mem_req.wdata = blank;
            sweep_in      = sweep_ff + tccs_pkg::ADDR_W'(1);
            if (sweep_ff == LAST_COL) begin
               state_in = printable ? ST_WRITE : ST_DONE;
            end
         end
         ST_WRITE: begin
            mem_req.we    = 1'b1;
            mem_req.row   = row_ff;
            mem_req.col   = col_ff;
            mem_req.wdata = {attr_ff, char_ff};
            col_in        = col_ff + tccs_pkg::COL_W'(1);
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_data_in  = {3'b000, scrolled_ff, col_ff, row_ff, cell_out};
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         top_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         attr_ff      <= tccs_pkg::RESET_ATTR;
         scrolled_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         top_ff       <= top_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         attr_ff      <= attr_in;
         scrolled_ff  <= scrolled_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      char_ff     <= char_in;
      rrow_ff     <= rrow_in;
      rcol_ff     <= rcol_in;
      rsp_data_ff <= rsp_data_in;
   end

   tccs_cell_store u_cell_store (
      .clock   (clock),
      .mem_req (mem_req),
      .top_row (top_ff),
      .rdata   (mem_rdata)
   );

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= LAST_ROW)
      else $error("cursor row out of range");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= COLS_C)
      else $error("cursor column past pending wrap");

   a_top_range: assert property (@(posedge clock) disable iff (reset)
      top_ff <= LAST_ROW)
      else $error("top row pointer out of range");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_req.we)
      else $error("cell store written while idle");

   a_clear_home: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && kind_ff == tccs_pkg::KIND_CLEAR) |=>
         (rsp_tdata[27:16] == '0) && !rsp_tdata[28])
      else $error("clear did not home the cursor");

endmodule
`default_nettype wire

// ===== dv/text_console_cursor_scroll_top_tb.sv =====
// self-checking stream testbench for the text console with cursor, tab, wrap and scroll
`timescale 1ns / 100ps
module text_console_cursor_scroll_top_tb;
   import tccs_pkg::*;

   localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CHAR_W-1:0] char_code;
      logic [ROW_W-1:0]  read_row;
      logic [COL_W-1:0]  read_col;
   } console_cmd_type;

   typedef struct packed {
      logic [CELL_W-1:0] cell_value;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic              scrolled;
   } cursor_report_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [KIND_W-1:0]   req_tuser = '0;  // kind
   logic [REQ_W-1:0]    req_tdata = '0;  // char_code, read_row, read_col
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;       // cell_value, cursor_row, cursor_col, scrolled
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [ATTR_W-1:0]   csr_wdata = '0;

   console_cmd_type     cmd_stream[$];
   cursor_report_type   cursor_reports[$];
   console_cmd_type     cmd_on_bus;
   int                  cmds_queued = 0;
   int                  errors = 0;
   int                  send_gap_pct = 23;
   int                  recv_stall_pct = 69;

   logic [CELL_W-1:0]   screen_mem [0:CELLS-1];
   int                  cur_row;
   int                  cur_col;
   logic [ATTR_W-1:0]   cur_attr;

   text_console_cursor_scroll_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic void paint_blank(logic [ATTR_W-1:0] a);
      for (int i = 0; i < CELLS; i++) screen_mem[i] = {a, CH_SPACE};
   endfunction

   // column 0 of the next row, scrolling up from the last row
   function automatic logic next_row();
      cur_col = 0;
      cur_row++;
      if (cur_row >= ROWS) begin
         for (int i = 0; i < CELLS - COLUMNS; i++) screen_mem[i] = screen_mem[i + COLUMNS];
         for (int c = 0; c < COLUMNS; c++)
            screen_mem[(ROWS - 1) * COLUMNS + c] = {cur_attr, CH_SPACE};
         cur_row = ROWS - 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic cursor_report_type console_step(console_cmd_type c);
      cursor_report_type rep;
      logic              sc;
      sc = 1'b0;
      rep.cell_value = '0;
      case (c.kind)
         KIND_PUT: begin
            if (c.char_code == CH_CR) begin
               cur_col = 0;
            end else if (c.char_code == CH_LF) begin
               sc = next_row();
            end else if (c.char_code == CH_TAB) begin
               cur_col = (cur_col / TAB_STOP + 1) * TAB_STOP;
               if (cur_col >= COLUMNS) sc = next_row();
            end else begin
               if (cur_col >= COLUMNS) sc = next_row();
               screen_mem[cur_row * COLUMNS + cur_col] = {cur_attr, c.char_code};
               cur_col++;
            end
         end
         KIND_CLEAR: begin
            paint_blank(cur_attr);
            cur_row = 0;
            cur_col = 0;
         end
         KIND_READ: begin
            if (c.read_row < ROWS && c.read_col < COLUMNS)
               rep.cell_value = screen_mem[c.read_row * COLUMNS + c.read_col];
         end
         default: ;
      endcase
      rep.row = cur_row[ROW_W-1:0];
      rep.col = cur_col[COL_W-1:0];
      rep.scrolled = sc;
      return rep;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tuser  <= '0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) cursor_reports.push_back(console_step(cmd_on_bus));
         if (!req_tvalid || req_tready) begin
            if (cmd_stream.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               cmd_on_bus = cmd_stream.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= cmd_on_bus.kind;
               req_tdata  <= {4'b0, cmd_on_bus.read_col, cmd_on_bus.read_row,
                              cmd_on_bus.char_code};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cursor_report_type want;
      cursor_report_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.cell_value = rsp_tdata[15:0];
            got.row        = rsp_tdata[20:16];
            got.col        = rsp_tdata[27:21];
            got.scrolled   = rsp_tdata[28];
            if (cursor_reports.size() == 0) begin
               $display("%0t: unexpected transaction cell %h row %0d col %0d scrolled %b",
                        $time, got.cell_value, got.row, got.col, got.scrolled);
               errors++;
            end else begin
               want = cursor_reports.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected cell %h row %0d col %0d scrolled %b, %s",
                           $time, want.cell_value, want.row, want.col, want.scrolled,
                           "actual");
                  $display("%0t:          actual   cell %h row %0d col %0d scrolled %b",
                           $time, got.cell_value, got.row, got.col, got.scrolled);
                  errors++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic push_cmd(logic [KIND_W-1:0] k, logic [CHAR_W-1:0] ch,
                           logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
      console_cmd_type c;
      c.kind      = k;
      c.char_code = ch;
      c.read_row  = rr;
      c.read_col  = rc;
      cmd_stream.push_back(c);
      cmds_queued++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (cmd_stream.size() != 0 || req_tvalid || cursor_reports.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_attr(logic [ATTR_W-1:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_attr = v;
   endtask

   // lines of text with random content, some long enough to wrap, plus reads, clears and noise
   task automatic gen_text(int target);
      int start;
      int len;
      int r;
      int i;
      start = cmds_queued;
      while (cmds_queued - start < target) begin
         if ($urandom_range(99) < 3)
            push_cmd(KIND_CLEAR, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
         len = ($urandom_range(3) == 0) ? $urandom_range(70, 95) : $urandom_range(0, 20);
         for (i = 0; i < len; i++) begin
            r = $urandom_range(99);
            if (r < 68)
               push_cmd(KIND_PUT, CHAR_W'($urandom_range(32, 126)), ROW_W'($urandom),
                        COL_W'($urandom));
            else if (r < 76)
               push_cmd(KIND_PUT, CH_TAB, ROW_W'($urandom), COL_W'($urandom));
            else if (r < 81)
               push_cmd(KIND_PUT, CHAR_W'($urandom_range(0, 255)), ROW_W'($urandom),
                        COL_W'($urandom));
            else if (r < 93)
               push_cmd(KIND_READ, CHAR_W'($urandom), ROW_W'($urandom_range(0, ROWS - 1)),
                        COL_W'($urandom_range(0, COLUMNS - 1)));
            else if (r < 97)
               push_cmd(KIND_READ, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
            else
               push_cmd(KIND_NONE, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
         end
         r = $urandom_range(99);
         if (r < 55) begin
            push_cmd(KIND_PUT, CH_LF, ROW_W'($urandom), COL_W'($urandom));
         end else if (r < 70) begin
            push_cmd(KIND_PUT, CH_CR, ROW_W'($urandom), COL_W'($urandom));
            push_cmd(KIND_PUT, CH_LF, ROW_W'($urandom), COL_W'($urandom));
         end else if (r < 80) begin
            push_cmd(KIND_PUT, CH_CR, ROW_W'($urandom), COL_W'($urandom));
         end else if (r < 88) begin
            len = $urandom_range(3, 12);
            for (i = 0; i < len; i++)
               push_cmd(KIND_PUT, CH_LF, ROW_W'($urandom), COL_W'($urandom));
         end
      end
   endtask

   initial begin
      int i;
      cur_attr = RESET_ATTR;
      cur_row  = 0;
      cur_col  = 0;
      paint_blank(RESET_ATTR);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      push_cmd(KIND_READ, 8'h00, 5'd0, 7'd0);
      push_cmd(KIND_READ, 8'h00, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
      push_cmd(KIND_PUT, 8'h41, 5'd0, 7'd0);
      push_cmd(KIND_PUT, 8'h00, 5'd0, 7'd0);
      push_cmd(KIND_PUT, 8'hFF, 5'h1F, 7'h7F);
      push_cmd(KIND_PUT, 8'h1B, 5'd0, 7'd0);
      push_cmd(KIND_READ, 8'h00, 5'd0, 7'd0);
      push_cmd(KIND_READ, 8'h00, 5'd0, 7'd3);
      push_cmd(KIND_READ, 8'h00, ROW_W'(ROWS), 7'd0);
      push_cmd(KIND_READ, 8'h00, 5'd0, COL_W'(COLUMNS));
      push_cmd(KIND_READ, 8'hFF, 5'h1F, 7'h7F);
      push_cmd(KIND_NONE, 8'hFF, 5'h1F, 7'h7F);
      push_cmd(KIND_PUT, CH_CR, 5'd0, 7'd0);
      push_cmd(KIND_PUT, CH_LF, 5'd0, 7'd0);
      // tabs across the row until one wraps to the next row
      for (i = 0; i < 10; i++) push_cmd(KIND_PUT, CH_TAB, 5'd0, 7'd0);
      push_cmd(KIND_CLEAR, 8'h00, 5'd0, 7'd0);
      push_cmd(KIND_READ, 8'h00, 5'd1, 7'd0);
      wait_drained();

      write_attr(8'hFF);
      gen_text(370);
      wait_drained();

      send_gap_pct   = 69;
      recv_stall_pct = 23;
      write_attr(8'h00);
      gen_text(370);
      wait_drained();

      send_gap_pct   = 0;
      recv_stall_pct = 0;
      write_attr(ATTR_W'($urandom_range(1, 254)));
      gen_text(370);
      wait_drained();
      repeat (2200) @(posedge clock);

      if (errors == 0 && cursor_reports.size() == 0)
         $display("[text_console_cursor_scroll_top] OK");
      else
         $display("[text_console_cursor_scroll_top] ERROR");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("[text_console_cursor_scroll_top] ERROR");
      $finish;
   end

endmodule
